@@ rtl/env_sensor_compensation_top_macros.svh @@
// Assertion helpers for the compensation block. Both expect clk and arst_n in scope.
`ifndef ENV_SENSOR_COMPENSATION_TOP_MACROS_SVH
`define ENV_SENSOR_COMPENSATION_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ESC_CHECK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ESC_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/esc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package esc_pkg;

	localparam int ESC_QDEPTH     = 4;
	localparam int ESC_QPTR_W     = $clog2(ESC_QDEPTH);
	localparam int ESC_FRONT_DEPTH = 5;
	localparam int ESC_BACK_DEPTH = 45;
	localparam int ESC_HUM_DLY    = 30;
	localparam int ESC_DIV_STEPS  = 32;

	localparam logic [31:0] ESC_RECIP100    = 32'h51EB_851F;
	localparam int          ESC_RECIP_SHIFT = 37;

	localparam logic [31:0] ESC_P_OFFSET   = 32'd64000;
	localparam logic [31:0] ESC_P_BIAS     = 32'd32768;
	localparam logic [31:0] ESC_P_FULL     = 32'd1048576;
	localparam logic [31:0] ESC_P_SCALE    = 32'd3125;
	localparam logic [31:0] ESC_P_SPLIT    = 32'h4000_0000;
	localparam logic [31:0] ESC_H_BIAS     = 32'd16384;
	localparam logic [31:0] ESC_H_SCALE    = 32'd1000;
	localparam logic [31:0] ESC_T_ROUND    = 32'd128;
	localparam logic [31:0] ESC_HUM_MAX32  = 32'd100000;
	localparam logic [16:0] ESC_HUM_MAX    = 17'd100000;

	typedef enum logic [2:0] {
		REG_TEMP    = 3'd0,
		REG_PRESS_A = 3'd1,
		REG_PRESS_B = 3'd2,
		REG_PRESS_T = 3'd3,
		REG_HUM     = 3'd4
	} reg_idx_t;

	// Calibration words, already sign or zero extended to 32 bits.
	typedef struct packed {
		logic [31:0] t1, t2, t3;
		logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, p10;
		logic [31:0] h1, h2, h3, h4, h5, h6, h7;
	} coef_t;

	typedef struct packed {
		logic [31:0] temp;
		logic [31:0] fine;
		logic [19:0] raw_p;
		logic [15:0] raw_h;
	} qitem_t;

	typedef struct packed {
		logic [31:0] temp;
		logic [31:0] press;
		logic [16:0] hum;
		logic        fault;
	} result_t;

	function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
		return 32'($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = 64'(a) * 64'(b);
		return p[31:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/esc_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module esc_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  esc_pkg::qitem_t      din,
	output logic                 full,
	input  wire logic            pop,
	output esc_pkg::qitem_t      dout,
	output logic                 empty
);
	esc_pkg::qitem_t mem_q [esc_pkg::ESC_QDEPTH];
	logic [esc_pkg::ESC_QPTR_W-1:0] wr_q, rd_q;
	logic [esc_pkg::ESC_QPTR_W:0]   cnt_q;

	assign full  = (cnt_q == (esc_pkg::ESC_QPTR_W+1)'(esc_pkg::ESC_QDEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/esc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module esc_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [19:0]     raw_t,
	input  wire logic [19:0]     raw_p,
	input  wire logic [15:0]     raw_h,
	input  esc_pkg::coef_t       coef,
	output logic                 push,
	input  wire logic            full,
	output esc_pkg::qitem_t      item
);
	logic [esc_pkg::ESC_FRONT_DEPTH-1:0] v_q;
	logic        en;
	logic [31:0] a_s1, bp_s2, dd_s2, b_s3, cp_s3, fine_s4, temp_s5, fine_s5;
	logic [19:0] rp_s1, rp_s2, rp_s3, rp_s4, rp_s5;
	logic [15:0] rh_s1, rh_s2, rh_s3, rh_s4, rh_s5;

	// Advance unless the last stage holds an item the queue cannot take.
	assign en       = !v_q[esc_pkg::ESC_FRONT_DEPTH-1] || !full;
	assign in_ready = en;
	assign push     = v_q[esc_pkg::ESC_FRONT_DEPTH-1] && !full;
	assign item     = '{temp: temp_s5, fine: fine_s5, raw_p: rp_s5, raw_h: rh_s5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[esc_pkg::ESC_FRONT_DEPTH-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= ({12'b0, raw_t} >> 3) - (coef.t1 << 1);
			rp_s1   <= raw_p;
			rh_s1   <= raw_h;
			bp_s2   <= esc_pkg::mul32(a_s1, coef.t2);
			dd_s2   <= esc_pkg::mul32(esc_pkg::asr(a_s1, 1), esc_pkg::asr(a_s1, 1));
			rp_s2   <= rp_s1;
			rh_s2   <= rh_s1;
			b_s3    <= esc_pkg::asr(bp_s2, 11);
			cp_s3   <= esc_pkg::mul32(esc_pkg::asr(dd_s2, 12), coef.t3 << 4);
			rp_s3   <= rp_s2;
			rh_s3   <= rh_s2;
			fine_s4 <= b_s3 + esc_pkg::asr(cp_s3, 14);
			rp_s4   <= rp_s3;
			rh_s4   <= rh_s3;
			temp_s5 <= esc_pkg::asr((fine_s4 << 2) + fine_s4 + esc_pkg::ESC_T_ROUND, 8);
			fine_s5 <= fine_s4;
			rp_s5   <= rp_s4;
			rh_s5   <= rh_s4;
		end
	end
endmodule
`default_nettype wire

@@ rtl/esc_div100.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Signed divide by 100, truncating toward zero; three stages.
module esc_div100 (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] x,
	output logic      [31:0] quo
);
	logic        neg_s1, neg_s2;
	logic [31:0] mag_s1, res_s3;
	logic [63-esc_pkg::ESC_RECIP_SHIFT:0] quo_s2;
	logic [63:0] prod;

	assign prod = 64'(mag_s1) * 64'(esc_pkg::ESC_RECIP100);
	assign quo  = res_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= x[31];
			mag_s1 <= x[31] ? (32'd0 - x) : x;
			neg_s2 <= neg_s1;
			quo_s2 <= prod[63:esc_pkg::ESC_RECIP_SHIFT];
			res_s3 <= neg_s2 ? (32'd0 - 32'(quo_s2)) : 32'(quo_s2);
		end
	end
endmodule
`default_nettype wire

@@ rtl/esc_sdiv.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Signed 32-bit divide, one quotient bit per stage; 34 stages in all.
module esc_sdiv (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] x,
	input  wire logic [31:0] y,
	input  wire logic [1:0]  tag_in,
	output logic      [31:0] quo,
	output logic      [1:0]  tag_out
);
	localparam int N = esc_pkg::ESC_DIV_STEPS;

	logic [31:0] mx_s0, my_s0;
	logic        neg_s0;
	logic [1:0]  tag_s0;
	logic [31:0] r_q   [N];
	logic [31:0] nq_q  [N];
	logic [31:0] my_q  [N];
	logic        neg_q [N];
	logic [1:0]  tag_q [N];
	logic [31:0] res_q;
	logic [1:0]  tago_q;

	function automatic logic [63:0] step(input logic [31:0] r, input logic [31:0] nq,
			input logic [31:0] d);
		logic [32:0] trial;
		logic [31:0] rn;
		logic        qb;
		trial = {r, nq[31]};
		if (trial >= {1'b0, d}) begin
			rn = 32'(trial - {1'b0, d});
			qb = 1'b1;
		end else begin
			rn = trial[31:0];
			qb = 1'b0;
		end
		return {rn, nq[30:0], qb};
	endfunction

	assign quo     = res_q;
	assign tag_out = tago_q;

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s0  <= x[31] ? (32'd0 - x) : x;
			my_s0  <= y[31] ? (32'd0 - y) : y;
			neg_s0 <= x[31] ^ y[31];
			tag_s0 <= tag_in;
			{r_q[0], nq_q[0]} <= step(32'd0, mx_s0, my_s0);
			my_q[0]  <= my_s0;
			neg_q[0] <= neg_s0;
			tag_q[0] <= tag_s0;
			for (int i = 1; i < N; i++) begin
				{r_q[i], nq_q[i]} <= step(r_q[i-1], nq_q[i-1], my_q[i-1]);
				my_q[i]  <= my_q[i-1];
				neg_q[i] <= neg_q[i-1];
				tag_q[i] <= tag_q[i-1];
			end
			res_q  <= neg_q[N-1] ? (32'd0 - nq_q[N-1]) : nq_q[N-1];
			tago_q <= tag_q[N-1];
		end
	end
endmodule
`default_nettype wire

@@ rtl/esc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module esc_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  esc_pkg::qitem_t      qi,
	input  wire logic            q_empty,
	output logic                 q_pop,
	input  esc_pkg::coef_t       coef,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output esc_pkg::result_t     res
);
	localparam int D = esc_pkg::ESC_BACK_DEPTH;
	localparam int H = esc_pkg::ESC_HUM_DLY;

	logic en;
	logic [D-1:0] v_q;
	logic [31:0] tdl_q [D];
	logic [16:0] hdl_q [H];

	// pressure path
	logic [31:0] pa_s1, m1_s2, m2_s2, m3_s2, b1_s3, a1_s3, m2_s3, m3_s3;
	logic [31:0] b_s4, as_s4, av_s5, pm_s5, pn_s6, av_s6;
	logic [19:0] rp_s1, rp_s2, rp_s3, rp_s4;
	logic        big, zdiv;
	logic [31:0] dq;
	logic [1:0]  dtag;
	logic [31:0] pr_s41, pr_s42, pr_s43, pr_s44, press_s45;
	logic [31:0] mdd_s42, m8_s42, d8_s42, mc1_s42, ma_s43, mc2_s43, m8_s43;
	logic [31:0] a_s44, b_s44, mc3_s44;
	logic        f_s41, f_s42, f_s43, f_s44, f_s45;

	// humidity path
	logic [31:0] x3_s1, x4_s1, x5_s1, x7_s1, ha_s1, ha_s2, ha_s3, ha_s4;
	logic [31:0] q3, q4, q5, q7, de;
	logic [31:0] e_s5, ha_s5, dd_s5, q4_s5;
	logic [31:0] ha_s6, ha_s7, ha_s8, dd_s6, dd_s7, dd_s8, q4_s6, q4_s7, q4_s8;
	logic [31:0] sum_s9, ha_s9, dd_s9, hb_s10, ha_s10, dd_s10;
	logic [31:0] c_s11, dd_s11, sq_s12, c_s12, dd_s12, bb_s13, c_s13, hp_s14;
	logic [31:0] hs;
	logic [16:0] hum_s15, hclamp;

	// Whole pipeline moves together; it stops only while the result waits.
	assign en        = !v_q[D-1] || out_ready;
	assign q_pop     = en && !q_empty;
	assign out_valid = v_q[D-1];
	assign res       = '{temp: tdl_q[D-1], press: press_s45, hum: hdl_q[H-1], fault: f_s45};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[D-2:0], !q_empty};
		end
	end

	// Divider setup: take the dividend whole above the split, else doubled.
	assign big  = $signed(pn_s6) >= $signed(esc_pkg::ESC_P_SPLIT);
	assign zdiv = (av_s6 == '0);

	esc_sdiv u_sdiv (
		.clk(clk), .en(en),
		.x(big ? pn_s6 : (pn_s6 << 1)), .y(av_s6), .tag_in({zdiv, big}),
		.quo(dq), .tag_out(dtag)
	);

	esc_div100 u_d3 (.clk(clk), .en(en), .x(x3_s1), .quo(q3));
	esc_div100 u_d4 (.clk(clk), .en(en), .x(x4_s1), .quo(q4));
	esc_div100 u_d5 (.clk(clk), .en(en), .x(x5_s1), .quo(q5));
	esc_div100 u_d7 (.clk(clk), .en(en), .x(x7_s1), .quo(q7));
	esc_div100 u_de (.clk(clk), .en(en), .x(esc_pkg::asr(e_s5, 6)), .quo(de));

	always_comb begin
		hs = esc_pkg::asr(hp_s14, 12);
		if ($signed(hs) > $signed(esc_pkg::ESC_HUM_MAX32)) begin
			hclamp = esc_pkg::ESC_HUM_MAX;
		end else if (hs[31]) begin
			hclamp = '0;
		end else begin
			hclamp = hs[16:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tdl_q[0] <= qi.temp;
			for (int i = 1; i < D; i++) begin
				tdl_q[i] <= tdl_q[i-1];
			end
			hdl_q[0] <= hum_s15;
			for (int i = 1; i < H; i++) begin
				hdl_q[i] <= hdl_q[i-1];
			end

			// pressure, ahead of the divider
			pa_s1 <= esc_pkg::asr(qi.fine, 1) - esc_pkg::ESC_P_OFFSET;
			rp_s1 <= qi.raw_p;
			m1_s2 <= esc_pkg::mul32(esc_pkg::asr(pa_s1, 2), esc_pkg::asr(pa_s1, 2));
			m2_s2 <= esc_pkg::mul32(pa_s1, coef.p5);
			m3_s2 <= esc_pkg::mul32(coef.p2, pa_s1);
			rp_s2 <= rp_s1;
			b1_s3 <= esc_pkg::mul32(esc_pkg::asr(m1_s2, 11), coef.p6);
			a1_s3 <= esc_pkg::mul32(esc_pkg::asr(m1_s2, 13), coef.p3 << 5);
			m2_s3 <= m2_s2;
			m3_s3 <= m3_s2;
			rp_s3 <= rp_s2;
			b_s4  <= esc_pkg::asr(esc_pkg::asr(b1_s3, 2) + (m2_s3 << 1), 2) + (coef.p4 << 16);
			as_s4 <= esc_pkg::ESC_P_BIAS
				+ esc_pkg::asr(esc_pkg::asr(a1_s3, 3) + esc_pkg::asr(m3_s3, 1), 18);
			rp_s4 <= rp_s3;
			av_s5 <= esc_pkg::asr(esc_pkg::mul32(as_s4, coef.p1), 15);
			pm_s5 <= (esc_pkg::ESC_P_FULL - {12'b0, rp_s4}) - esc_pkg::asr(b_s4, 12);
			pn_s6 <= esc_pkg::mul32(pm_s5, esc_pkg::ESC_P_SCALE);
			av_s6 <= av_s5;

			// pressure, after the divider
			pr_s41  <= dtag[0] ? (dq << 1) : dq;
			f_s41   <= dtag[1];
			mdd_s42 <= esc_pkg::mul32(esc_pkg::asr(pr_s41, 3), esc_pkg::asr(pr_s41, 3));
			m8_s42  <= esc_pkg::mul32(esc_pkg::asr(pr_s41, 2), coef.p8);
			d8_s42  <= esc_pkg::asr(pr_s41, 8);
			mc1_s42 <= esc_pkg::mul32(esc_pkg::asr(pr_s41, 8), esc_pkg::asr(pr_s41, 8));
			pr_s42  <= pr_s41;
			f_s42   <= f_s41;
			ma_s43  <= esc_pkg::mul32(coef.p9, esc_pkg::asr(mdd_s42, 13));
			mc2_s43 <= esc_pkg::mul32(mc1_s42, d8_s42);
			m8_s43  <= m8_s42;
			pr_s43  <= pr_s42;
			f_s43   <= f_s42;
			a_s44   <= esc_pkg::asr(ma_s43, 12);
			b_s44   <= esc_pkg::asr(m8_s43, 13);
			mc3_s44 <= esc_pkg::mul32(mc2_s43, coef.p10);
			pr_s44  <= pr_s43;
			f_s44   <= f_s43;
			press_s45 <= f_s44 ? '0 : pr_s44
				+ esc_pkg::asr(a_s44 + b_s44 + esc_pkg::asr(mc3_s44, 17) + (coef.p7 << 7), 4);
			f_s45   <= f_s44;

			// humidity
			x3_s1 <= esc_pkg::mul32(qi.temp, coef.h3);
			x4_s1 <= esc_pkg::mul32(qi.temp, coef.h4);
			x5_s1 <= esc_pkg::mul32(qi.temp, coef.h5);
			x7_s1 <= esc_pkg::mul32(qi.temp, coef.h7);
			ha_s1 <= {16'b0, qi.raw_h} - (coef.h1 << 4);
			ha_s2 <= ha_s1;
			ha_s3 <= ha_s2;
			ha_s4 <= ha_s3;
			e_s5  <= esc_pkg::mul32(tdl_q[3], q5);
			ha_s5 <= ha_s4 - esc_pkg::asr(q3, 1);
			dd_s5 <= esc_pkg::asr((coef.h6 << 7) + q7, 4);
			q4_s5 <= q4;
			ha_s6 <= ha_s5;
			ha_s7 <= ha_s6;
			ha_s8 <= ha_s7;
			dd_s6 <= dd_s5;
			dd_s7 <= dd_s6;
			dd_s8 <= dd_s7;
			q4_s6 <= q4_s5;
			q4_s7 <= q4_s6;
			q4_s8 <= q4_s7;
			sum_s9 <= q4_s8 + de + esc_pkg::ESC_H_BIAS;
			ha_s9  <= ha_s8;
			dd_s9  <= dd_s8;
			hb_s10 <= esc_pkg::asr(esc_pkg::mul32(coef.h2, sum_s9), 10);
			ha_s10 <= ha_s9;
			dd_s10 <= dd_s9;
			c_s11  <= esc_pkg::mul32(ha_s10, hb_s10);
			dd_s11 <= dd_s10;
			sq_s12 <= esc_pkg::mul32(esc_pkg::asr(c_s11, 14), esc_pkg::asr(c_s11, 14));
			c_s12  <= c_s11;
			dd_s12 <= dd_s11;
			bb_s13 <= esc_pkg::mul32(dd_s12, esc_pkg::asr(sq_s12, 10));
			c_s13  <= c_s12;
			hp_s14 <= esc_pkg::mul32(esc_pkg::asr(c_s13 + esc_pkg::asr(bb_s13, 1), 10),
				esc_pkg::ESC_H_SCALE);
			hum_s15 <= hclamp;
		end
	end
endmodule
`default_nettype wire

@@ rtl/env_sensor_compensation_top.sv @@
// Environmental sensor compensation. Each item on the s_ stream carries one raw sample
// (temperature, pressure and humidity ADC codes); each item on the m_ stream carries the
// compensated temperature in 0.01 degC, pressure in Pa, humidity in 0.001 %RH (held to
// 0..100000) and, in m_tuser, a flag that marks a zero pressure divisor (pressure then
// reads 0). All arithmetic is 32-bit two's complement with wraparound. The block takes
// one item per clock for as long as m_tready stays high. A sample passes 5 front stages
// for the temperature term, then the queue, then 45 back stages, of which 34 are the
// bit-per-stage pressure divider that sets the depth. A four-entry queue sits between
// front and back, so the input keeps flowing for a few items after the output stalls.
// Calibration is written over the APB port at byte addresses 0x00, 0x08, 0x10, 0x18 and
// 0x20, only while no sample is in flight; the user must ensure this, the block does not.
`timescale 1ns / 1ps
`default_nettype none
module env_sensor_compensation_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// raw_temperature [19:0], raw_pressure [39:20], raw_humidity [55:40]
	input  wire logic [55:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// temperature_centi [31:0], pressure_pascal [63:32], humidity_milli [80:64], zero [87:81]
	output logic      [87:0] m_tdata,
	// calib_fault [0]
	output logic      [0:0]  m_tuser,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready
);
`include "env_sensor_compensation_top_macros.svh"

	logic [39:0] temp_coeffs_q;
	logic [55:0] press_coeffs_a_q;
	logic [63:0] press_coeffs_b_q;
	logic [7:0]  press_coeff_ten_q;
	logic [63:0] hum_coeffs_q;
	esc_pkg::reg_idx_t ridx;
	esc_pkg::coef_t    coef;
	esc_pkg::qitem_t   fq_item, bq_item;
	esc_pkg::result_t  res;
	logic push, full, pop, empty;

	assign pready = 1'b1;
	assign ridx   = esc_pkg::reg_idx_t'(paddr[5:3]);

	// Register write: commit in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q     <= '0;
			press_coeffs_a_q  <= '0;
			press_coeffs_b_q  <= '0;
			press_coeff_ten_q <= '0;
			hum_coeffs_q      <= '0;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				esc_pkg::REG_TEMP:    temp_coeffs_q     <= pwdata[39:0];
				esc_pkg::REG_PRESS_A: press_coeffs_a_q  <= pwdata[55:0];
				esc_pkg::REG_PRESS_B: press_coeffs_b_q  <= pwdata;
				esc_pkg::REG_PRESS_T: press_coeff_ten_q <= pwdata[7:0];
				esc_pkg::REG_HUM:     hum_coeffs_q      <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			esc_pkg::REG_TEMP:    prdata = {24'b0, temp_coeffs_q};
			esc_pkg::REG_PRESS_A: prdata = {8'b0, press_coeffs_a_q};
			esc_pkg::REG_PRESS_B: prdata = press_coeffs_b_q;
			esc_pkg::REG_PRESS_T: prdata = {56'b0, press_coeff_ten_q};
			esc_pkg::REG_HUM:     prdata = hum_coeffs_q;
			default:              prdata = '0;
		endcase
	end

	// Unpack calibration fields, extending each to a full 32-bit word.
	always_comb begin
		coef.t1  = {16'b0, temp_coeffs_q[15:0]};
		coef.t2  = {{16{temp_coeffs_q[31]}}, temp_coeffs_q[31:16]};
		coef.t3  = {{24{temp_coeffs_q[39]}}, temp_coeffs_q[39:32]};
		coef.p1  = {16'b0, press_coeffs_a_q[15:0]};
		coef.p2  = {{16{press_coeffs_a_q[31]}}, press_coeffs_a_q[31:16]};
		coef.p3  = {{24{press_coeffs_a_q[39]}}, press_coeffs_a_q[39:32]};
		coef.p4  = {{16{press_coeffs_a_q[55]}}, press_coeffs_a_q[55:40]};
		coef.p5  = {{16{press_coeffs_b_q[15]}}, press_coeffs_b_q[15:0]};
		coef.p6  = {{24{press_coeffs_b_q[23]}}, press_coeffs_b_q[23:16]};
		coef.p7  = {{24{press_coeffs_b_q[31]}}, press_coeffs_b_q[31:24]};
		coef.p8  = {{16{press_coeffs_b_q[47]}}, press_coeffs_b_q[47:32]};
		coef.p9  = {{16{press_coeffs_b_q[63]}}, press_coeffs_b_q[63:48]};
		coef.p10 = {24'b0, press_coeff_ten_q};
		coef.h1  = {20'b0, hum_coeffs_q[11:0]};
		coef.h2  = {20'b0, hum_coeffs_q[23:12]};
		coef.h3  = {{24{hum_coeffs_q[31]}}, hum_coeffs_q[31:24]};
		coef.h4  = {{24{hum_coeffs_q[39]}}, hum_coeffs_q[39:32]};
		coef.h5  = {{24{hum_coeffs_q[47]}}, hum_coeffs_q[47:40]};
		coef.h6  = {24'b0, hum_coeffs_q[55:48]};
		coef.h7  = {{24{hum_coeffs_q[63]}}, hum_coeffs_q[63:56]};
	end

	// Front: accept samples and form the fine temperature term.
	esc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.raw_t(s_tdata[19:0]), .raw_p(s_tdata[39:20]), .raw_h(s_tdata[55:40]),
		.coef(coef), .push(push), .full(full), .item(fq_item)
	);

	esc_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .din(fq_item), .full(full),
		.pop(pop), .dout(bq_item), .empty(empty)
	);

	// Back: pressure with its divider, humidity, and the output register.
	esc_back u_back (
		.clk(clk), .arst_n(arst_n),
		.qi(bq_item), .q_empty(empty), .q_pop(pop), .coef(coef),
		.out_valid(m_tvalid), .out_ready(m_tready), .res(res)
	);

	assign m_tdata = {7'b0, res.hum, res.press, res.temp};
	assign m_tuser = res.fault;

	`ESC_CHECK_NOW(a_fault_zero, m_tvalid && m_tuser[0], m_tdata[63:32] == 32'd0, "fault with nonzero pressure")
	`ESC_CHECK_NOW(a_hum_range, m_tvalid, m_tdata[80:64] <= esc_pkg::ESC_HUM_MAX, "humidity above limit")
	`ESC_CHECK_NEXT(a_hold_result, m_tvalid && !m_tready && s_tvalid, m_tvalid, "result dropped while stalled")

endmodule
`default_nettype wire
